// ----- sv/dprp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dprp_pkg
// Shared constants, codes and types of the pitch record/playback tone
// generator, including the sine lookup table built at elaboration.
// ----------------------------------------------------------------------------
package dprp_pkg;

   // sizes
   localparam int SLOT_DEPTH    = 4096;
   localparam int NUM_SLOTS     = 9;
   localparam int COMPOSE_DEPTH = 20;
   localparam int SINE_ENTRIES  = 256;
   localparam int OUT_DEPTH     = 4;

   // field and register widths
   localparam int OP_W       = 3;
   localparam int SLOT_W     = 4;
   localparam int PITCH_W    = 12;
   localparam int DAC_W      = 16;
   localparam int SINE_W     = 12;
   localparam int PHASE_W    = 32;
   localparam int HOLD_W     = 8;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 32;

   // derived widths
   localparam int POS_W       = $clog2(SLOT_DEPTH + 1);
   localparam int OFS_W       = $clog2(SLOT_DEPTH);
   localparam int SLOT_IDX_W  = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int STORE_WORDS = NUM_SLOTS * SLOT_DEPTH;
   localparam int STORE_AW    = $clog2(STORE_WORDS);
   localparam int CLEN_W      = $clog2(COMPOSE_DEPTH + 1);
   localparam int CLIST_IDX_W = (COMPOSE_DEPTH > 1) ? $clog2(COMPOSE_DEPTH) : 1;
   localparam int SINE_IDX_W  = $clog2(SINE_ENTRIES);
   localparam int OUT_PTR_W   = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_W   = $clog2(OUT_DEPTH + 1);
   localparam int OCC_W       = $clog2(OUT_DEPTH + 3);

   // operation codes
   localparam logic [OP_W-1:0] OP_TICK    = 3'd0;
   localparam logic [OP_W-1:0] OP_RECORD  = 3'd1;
   localparam logic [OP_W-1:0] OP_PLAY    = 3'd2;
   localparam logic [OP_W-1:0] OP_APPEND  = 3'd3;
   localparam logic [OP_W-1:0] OP_COMPOSE = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PHASE_STEP = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD_TICKS = 1'd1;

   // register reset values
   localparam logic [PHASE_W-1:0] PHASE_STEP_RST = 32'd214748;
   localparam logic [HOLD_W-1:0]  HOLD_TICKS_RST = 8'd50;

   // dac channel select bits
   localparam logic [DAC_W-1:0] DAC_CHAN_B = 16'hB000;

   // fixed point constants for the table build
   localparam logic [63:0] PI_Q60    = 64'h3243_F6A8_885A_308D;
   localparam logic [63:0] ANGLE_DEN = 64'(1000 * SINE_ENTRIES);
   localparam logic [63:0] LOW30     = 64'h3FFF_FFFF;

   typedef logic [SINE_ENTRIES-1:0][SINE_W-1:0] sine_rom_type;

   typedef struct packed {
      logic [DAC_W-1:0] dac_word;
      logic             last;
   } rsp_entry_type;

   // q60 product, truncated
   function automatic logic [63:0] qmul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return p[123:60];
   endfunction

   // sine table with the +2048 offset already applied
   function automatic sine_rom_type build_sine_rom();
      sine_rom_type rom;
      logic [63:0]  q;
      logic [63:0]  r;
      logic [63:0]  x2;
      logic [63:0]  t;
      logic [63:0]  s;
      logic [63:0]  m;
      logic         neg;
      rom = '0;
      for (int k = 0; k < SINE_ENTRIES; k++) begin
         q = 64'(k * 6283) / ANGLE_DEN;
         r = 64'(k * 6283) % ANGLE_DEN;
         for (int b = 0; b < 60; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ANGLE_DEN) begin
               r    = r - ANGLE_DEN;
               q[0] = 1'b1;
            end
         end
         neg = 1'b0;
         if (q > PI_Q60) begin
            q   = q - PI_Q60;
            neg = 1'b1;
         end
         if (q > (PI_Q60 >> 1)) q = PI_Q60 - q;
         x2 = qmul(q, q);
         t  = q;
         s  = q;
         for (int n = 1; n <= 13; n++) begin
            t = qmul(t, x2) / 64'((2 * n) * (2 * n + 1));
            if ((n & 1) == 1) s = s - t;
            else s = s + t;
         end
         m = (((s >> 30) * 64'd2047) + (((s & LOW30) * 64'd2047) >> 30)) >> 30;
         rom[k] = neg ? (12'd2048 - m[SINE_W-1:0]) : (12'd2048 + m[SINE_W-1:0]);
      end
      return rom;
   endfunction

   localparam sine_rom_type SINE_ROM = build_sine_rom();

endpackage

// ----- sv/dprp_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dprp_req_if
// Request channel: ticks, record samples, playback and compose commands.
// ----------------------------------------------------------------------------
interface dprp_req_if;
   import dprp_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [OP_W-1:0]      op;
   logic [SLOT_W-1:0]    slot;
   logic [PITCH_W-1:0]   pitch_value;
   logic                 live_on;
   logic                 first_sample;

   modport source (
      output valid, op, slot, pitch_value, live_on, first_sample,
      input  ready
   );

   modport sink (
      input  valid, op, slot, pitch_value, live_on, first_sample,
      output ready
   );
endinterface

// ----- sv/dprp_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dprp_rsp_if
// Response channel: dac command words with an end-of-tick marker.
// ----------------------------------------------------------------------------
interface dprp_rsp_if;
   import dprp_pkg::*;

   logic               valid;
   logic               ready;
   logic [DAC_W-1:0]   dac_word;
   logic               last;

   modport source (
      output valid, dac_word, last,
      input  ready
   );

   modport sink (
      input  valid, dac_word, last,
      output ready
   );
endinterface

// ----- sv/dds_pitch_record_playback_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_pitch_record_playback_unit
// DDS tone generator with pitch recording into slots, single-slot playback
// and playback of a composed list of slots, built around a sample memory.
// ----------------------------------------------------------------------------
// A tick steps the engine through the compose, playback and emit states, the
// last once per dac word; a record passes the record state, other commands
// finish in idle. Tick lookups are paced by the single read port of the slot
// length and sample memories. Words go out one a cycle while the queue has room
// via the product register, the shared phase accumulator and the queue.
// Synchronous reset clears all control state; the sample memory is not cleared.
module dds_pitch_record_playback_unit (
   input  logic                               clock,
   input  logic                               reset,
   dprp_req_if.sink                           req_chan,
   dprp_rsp_if.source                         rsp_chan,
   input  logic                               csr_we,
   input  logic [dprp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [dprp_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import dprp_pkg::*;

   // engine states
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_REC  = 3'd1;
   localparam logic [2:0] ST_CMP  = 3'd2;
   localparam logic [2:0] ST_PLY  = 3'd3;
   localparam logic [2:0] ST_EMIT = 3'd4;

   // pending word bits, in output order
   localparam int PEND_LIVE = 0;
   localparam int PEND_COMP = 1;
   localparam int PEND_PLAY = 2;

   function automatic logic [SLOT_IDX_W-1:0] slot_index(logic [SLOT_W-1:0] s);
      return SLOT_IDX_W'(s - SLOT_W'(1));
   endfunction

   function automatic logic slot_valid(logic [SLOT_W-1:0] s);
      return (s >= SLOT_W'(1)) && (s <= SLOT_W'(NUM_SLOTS));
   endfunction

   function automatic logic [STORE_AW-1:0] store_addr(logic [SLOT_IDX_W-1:0] si,
                                                       logic [POS_W-1:0] pos);
      return STORE_AW'(si) * STORE_AW'(SLOT_DEPTH) + STORE_AW'(pos[OFS_W-1:0]);
   endfunction

   // configuration registers
   logic [PHASE_W-1:0]   phase_step_ff;
   logic [HOLD_W-1:0]    hold_ticks_ff;

   // input holding register
   logic                 item_vld_ff, item_vld_in;
   logic [OP_W-1:0]      item_op_ff;
   logic [SLOT_W-1:0]    item_slot_ff;
   logic [PITCH_W-1:0]   item_pitch_ff;
   logic                 item_live_ff;
   logic                 item_first_ff;
   logic                 req_take;
   logic                 consume;

   // working copy of the item in the engine
   logic [SLOT_W-1:0]    w_slot_ff;
   logic [PITCH_W-1:0]   w_pitch_ff;
   logic                 w_first_ff;

   // engine control state
   logic [2:0]           state_ff, state_in;
   logic                 compose_active_ff, compose_active_in;
   logic [CLEN_W-1:0]    compose_len_ff, compose_len_in;
   logic [CLEN_W-1:0]    compose_pos_ff, compose_pos_in;
   logic [POS_W-1:0]     compose_spos_ff, compose_spos_in;
   logic                 play_active_ff, play_active_in;
   logic [SLOT_W-1:0]    play_slot_ff, play_slot_in;
   logic [POS_W-1:0]     play_pos_ff, play_pos_in;
   logic [HOLD_W-1:0]    hold_ff, hold_in;
   logic [2:0]           pend_ff, pend_in;
   logic [2:0]           pend_rest;
   logic [2:0]           pend_nx;
   logic [PITCH_W-1:0]   comp_pitch_ff;

   // compose list
   logic [SLOT_W-1:0]    clist_ff [COMPOSE_DEPTH];
   logic                 clist_we;
   logic [SLOT_W-1:0]    cur_cs;
   logic                 comp_go;

   // slot length memory
   logic [POS_W-1:0]     len_mem [NUM_SLOTS];
   logic [NUM_SLOTS-1:0] len_vld_ff;
   logic [POS_W-1:0]     len_rd_ff;
   logic                 len_rd_vld_ff;
   logic                 len_re, len_we;
   logic [SLOT_IDX_W-1:0] len_ridx, len_widx;
   logic [POS_W-1:0]     len_wdata;
   logic [POS_W-1:0]     len_q;
   logic [POS_W-1:0]     rec_len;

   // sample memory
   logic [PITCH_W-1:0]   store_mem [STORE_WORDS];
   logic [PITCH_W-1:0]   store_rd_ff;
   logic                 st_re, st_we;
   logic [STORE_AW-1:0]  st_raddr, st_waddr;
   logic [PITCH_W-1:0]   st_wdata;

   // word generation pipeline
   logic                 issue_vld;
   logic [PITCH_W-1:0]   issue_pitch;
   logic                 issue_last;
   logic                 v1_ff, v2_ff;
   logic                 last1_ff, last2_ff;
   logic [PHASE_W-1:0]   prod_ff;
   logic [PHASE_W-1:0]   phase_ff;
   logic [SINE_IDX_W-1:0] sine_idx;
   logic [OCC_W-1:0]     occ;

   // output queue
   rsp_entry_type        fifo_ff [OUT_DEPTH];
   logic [OUT_PTR_W-1:0] fifo_wr_ff, fifo_rd_ff;
   logic [OUT_CNT_W-1:0] fifo_cnt_ff;
   logic                 push, pop;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff <= PHASE_STEP_RST;
         hold_ticks_ff <= HOLD_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_PHASE_STEP: phase_step_ff <= csr_wdata[PHASE_W-1:0];
            CSR_HOLD_TICKS: hold_ticks_ff <= csr_wdata[HOLD_W-1:0];
            default: ;
         endcase
      end
   end

   // input register: takes a new transaction while the engine works
   assign consume        = (state_ff == ST_IDLE) && item_vld_ff;
   assign req_chan.ready = !item_vld_ff || consume;
   assign req_take       = req_chan.valid && req_chan.ready;
   assign item_vld_in    = req_take || (item_vld_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
      end else begin
         item_vld_ff <= item_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         item_op_ff    <= req_chan.op;
         item_slot_ff  <= req_chan.slot;
         item_pitch_ff <= req_chan.pitch_value;
         item_live_ff  <= req_chan.live_on;
         item_first_ff <= req_chan.first_sample;
      end
      if (consume) begin
         w_slot_ff  <= item_slot_ff;
         w_pitch_ff <= item_pitch_ff;
         w_first_ff <= item_first_ff;
      end
      if (state_ff == ST_PLY) begin
         comp_pitch_ff <= store_rd_ff;
      end
   end

   // lookups shared by the engine states
   assign cur_cs    = clist_ff[compose_pos_ff[CLIST_IDX_W-1:0]];
   assign comp_go   = compose_active_ff && (compose_pos_ff < compose_len_ff);
   assign len_q     = len_rd_vld_ff ? len_rd_ff : '0;
   assign rec_len   = w_first_ff ? '0 : len_q;
   assign pend_rest = pend_ff & (pend_ff - 3'd1);
   assign occ       = OCC_W'(fifo_cnt_ff) + OCC_W'(v1_ff) + OCC_W'(v2_ff);

   // engine sequencer
   always_comb begin
      state_in          = state_ff;
      compose_active_in = compose_active_ff;
      compose_len_in    = compose_len_ff;
      compose_pos_in    = compose_pos_ff;
      compose_spos_in   = compose_spos_ff;
      play_active_in    = play_active_ff;
      play_slot_in      = play_slot_ff;
      play_pos_in       = play_pos_ff;
      hold_in           = hold_ff;
      pend_in           = pend_ff;
      pend_nx           = pend_ff;
      clist_we          = 1'b0;
      len_re            = 1'b0;
      len_ridx          = '0;
      len_we            = 1'b0;
      len_widx          = '0;
      len_wdata         = '0;
      st_re             = 1'b0;
      st_raddr          = '0;
      st_we             = 1'b0;
      st_waddr          = '0;
      st_wdata          = '0;
      issue_vld         = 1'b0;
      issue_pitch       = '0;
      issue_last        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_vld_ff) begin
               unique case (item_op_ff)
                  OP_TICK: begin
                     // live word first; fetch the compose slot length
                     pend_in = {2'b00, item_live_ff};
                     if (comp_go) begin
                        len_re   = 1'b1;
                        len_ridx = slot_index(cur_cs);
                     end
                     state_in = ST_CMP;
                  end
                  OP_RECORD: begin
                     if (slot_valid(item_slot_ff)) begin
                        len_re   = 1'b1;
                        len_ridx = slot_index(item_slot_ff);
                        state_in = ST_REC;
                     end
                  end
                  OP_PLAY: begin
                     if (slot_valid(item_slot_ff)) begin
                        play_active_in = 1'b1;
                        play_slot_in   = item_slot_ff;
                     end
                  end
                  OP_APPEND: begin
                     if (slot_valid(item_slot_ff) &&
                         (compose_len_ff < CLEN_W'(COMPOSE_DEPTH))) begin
                        clist_we       = 1'b1;
                        compose_len_in = compose_len_ff + CLEN_W'(1);
                     end
                  end
                  OP_COMPOSE: begin
                     compose_active_in = 1'b1;
                  end
                  default: ;
               endcase
            end
         end

         ST_REC: begin
            // append the sample unless the slot is full
            if (rec_len < POS_W'(SLOT_DEPTH)) begin
               st_we     = 1'b1;
               st_waddr  = store_addr(slot_index(w_slot_ff), rec_len);
               st_wdata  = w_pitch_ff;
               len_we    = 1'b1;
               len_widx  = slot_index(w_slot_ff);
               len_wdata = rec_len + POS_W'(1);
            end
            state_in = ST_IDLE;
         end

         ST_CMP: begin
            // compose playback step
            if (compose_active_ff) begin
               if (comp_go) begin
                  if (compose_spos_ff < len_q) begin
                     if (hold_ff < hold_ticks_ff) begin
                        pend_in[PEND_COMP] = 1'b1;
                        st_re    = 1'b1;
                        st_raddr = store_addr(slot_index(cur_cs), compose_spos_ff);
                        hold_in  = hold_ff + HOLD_W'(1);
                     end else begin
                        hold_in         = '0;
                        compose_spos_in = compose_spos_ff + POS_W'(1);
                     end
                  end else begin
                     compose_spos_in = '0;
                     compose_pos_in  = compose_pos_ff + CLEN_W'(1);
                  end
               end else begin
                  compose_pos_in    = '0;
                  compose_len_in    = '0;
                  compose_active_in = 1'b0;
               end
            end
            if (play_active_ff) begin
               len_re   = 1'b1;
               len_ridx = slot_index(play_slot_ff);
            end
            state_in = ST_PLY;
         end

         ST_PLY: begin
            // single slot playback step, sees the hold count left by compose
            if (play_active_ff) begin
               if (play_pos_ff < len_q) begin
                  if (hold_ff < hold_ticks_ff) begin
                     pend_nx[PEND_PLAY] = 1'b1;
                     st_re    = 1'b1;
                     st_raddr = store_addr(slot_index(play_slot_ff), play_pos_ff);
                     hold_in  = hold_ff + HOLD_W'(1);
                  end else begin
                     hold_in     = '0;
                     play_pos_in = play_pos_ff + POS_W'(1);
                  end
               end else begin
                  play_pos_in    = '0;
                  play_active_in = 1'b0;
               end
            end
            pend_in  = pend_nx;
            state_in = (pend_nx != 3'd0) ? ST_EMIT : ST_IDLE;
         end

         ST_EMIT: begin
            // one word per cycle in order, as long as the queue has room
            if (occ < OCC_W'(OUT_DEPTH)) begin
               issue_vld = 1'b1;
               if (pend_ff[PEND_LIVE]) begin
                  issue_pitch = w_pitch_ff;
               end else if (pend_ff[PEND_COMP]) begin
                  issue_pitch = comp_pitch_ff;
               end else begin
                  issue_pitch = store_rd_ff;
               end
               issue_last = (pend_rest == 3'd0);
               pend_in    = pend_rest;
               if (pend_rest == 3'd0) state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= ST_IDLE;
         compose_active_ff <= 1'b0;
         compose_len_ff    <= '0;
         compose_pos_ff    <= '0;
         compose_spos_ff   <= '0;
         play_active_ff    <= 1'b0;
         play_slot_ff      <= '0;
         play_pos_ff       <= '0;
         hold_ff           <= '0;
         pend_ff           <= '0;
      end else begin
         state_ff          <= state_in;
         compose_active_ff <= compose_active_in;
         compose_len_ff    <= compose_len_in;
         compose_pos_ff    <= compose_pos_in;
         compose_spos_ff   <= compose_spos_in;
         play_active_ff    <= play_active_in;
         play_slot_ff      <= play_slot_in;
         play_pos_ff       <= play_pos_in;
         hold_ff           <= hold_in;
         pend_ff           <= pend_in;
      end
   end

   // compose list write
   always_ff @(posedge clock) begin
      if (clist_we) begin
         clist_ff[compose_len_ff[CLIST_IDX_W-1:0]] <= item_slot_ff;
      end
   end

   // slot length memory, entries read as zero until written
   always_ff @(posedge clock) begin
      if (len_we) len_mem[len_widx] <= len_wdata;
      if (len_re) len_rd_ff <= len_mem[len_ridx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_vld_ff    <= '0;
         len_rd_vld_ff <= 1'b0;
      end else begin
         if (len_we) len_vld_ff[len_widx] <= 1'b1;
         if (len_re) len_rd_vld_ff <= len_vld_ff[len_ridx];
      end
   end

   // sample memory
   always_ff @(posedge clock) begin
      if (st_we) store_mem[st_waddr] <= st_wdata;
      if (st_re) store_rd_ff <= store_mem[st_raddr];
   end

   // phase pipeline: multiply, accumulate, table lookup
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         v2_ff    <= 1'b0;
         phase_ff <= '0;
      end else begin
         v1_ff <= issue_vld;
         v2_ff <= v1_ff;
         if (v1_ff) phase_ff <= phase_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (issue_vld) begin
         prod_ff  <= phase_step_ff * PHASE_W'(issue_pitch);
         last1_ff <= issue_last;
      end
      last2_ff <= last1_ff;
   end

   assign sine_idx = SINE_IDX_W'((64'(phase_ff) * 64'(SINE_ENTRIES)) >> PHASE_W);

   // response queue
   assign push = v2_ff;
   assign pop  = rsp_chan.valid && rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (push) begin
         fifo_ff[fifo_wr_ff].dac_word <= DAC_CHAN_B | DAC_W'(SINE_ROM[sine_idx]);
         fifo_ff[fifo_wr_ff].last     <= last2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_wr_ff  <= '0;
         fifo_rd_ff  <= '0;
         fifo_cnt_ff <= '0;
      end else begin
         if (push) fifo_wr_ff <= fifo_wr_ff + OUT_PTR_W'(1);
         if (pop)  fifo_rd_ff <= fifo_rd_ff + OUT_PTR_W'(1);
         case ({push, pop})
            2'b10:   fifo_cnt_ff <= fifo_cnt_ff + OUT_CNT_W'(1);
            2'b01:   fifo_cnt_ff <= fifo_cnt_ff - OUT_CNT_W'(1);
            default: fifo_cnt_ff <= fifo_cnt_ff;
         endcase
      end
   end

   assign rsp_chan.valid    = (fifo_cnt_ff != '0);
   assign rsp_chan.dac_word = fifo_ff[fifo_rd_ff].dac_word;
   assign rsp_chan.last     = fifo_ff[fifo_rd_ff].last;

endmodule

// ----- sv/dprp_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dprp_checker
// Port level checks of the tone generator, attached to the top by bind.
// ----------------------------------------------------------------------------
module dprp_checker (
   input logic        clock,
   input logic        reset,
   dprp_req_if.sink   req_chan,
   dprp_rsp_if.source rsp_chan
);
   import dprp_pkg::*;

   // a stalled response transaction keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && !rsp_chan.ready |=>
         rsp_chan.valid && $stable(rsp_chan.dac_word) && $stable(rsp_chan.last))
   else $error("response changed while stalled");

   // every word addresses dac channel b
   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> rsp_chan.dac_word[DAC_W-1:DAC_W-4] == DAC_CHAN_B[DAC_W-1:DAC_W-4])
   else $error("dac word without channel select bits");

   // reset empties the response queue
   assert property (@(posedge clock) reset |=> !rsp_chan.valid)
   else $error("response valid right after reset");

   // reset empties the input register
   assert property (@(posedge clock) reset |=> req_chan.ready)
   else $error("request not ready right after reset");

endmodule

bind dds_pitch_record_playback_unit dprp_checker u_dprp_checker (
   .clock    (clock),
   .reset    (reset),
   .req_chan (req_chan),
   .rsp_chan (rsp_chan)
);

// ----- bench/dds_pitch_record_playback_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_pitch_record_playback_unit_test
// Self-checking bench for the pitch record/playback tone generator. A driver
// fed from a command queue sends ticks, records, playback and compose
// commands with random idle cycles. A predictor tracks the phase, the slots
// and both playback paths, and works out the dac words of every tick. A
// monitor with random back-pressure checks each response transaction
// against the oldest predicted word. Several register settings are covered,
// including zero and full-scale phase steps and the hold extremes.
// ----------------------------------------------------------------------------
module dds_pitch_record_playback_unit_test;
   import dprp_pkg::*;

   localparam int unsigned CYCLE_LIMIT      = 600000;
   localparam int unsigned SETTLE_CYCLES    = 20;
   localparam int unsigned RANDOM_PER_PHASE = 14;
   localparam int unsigned RANDOM_PHASES    = 5;
   localparam int unsigned FILL_RECORDS     = 8;
   localparam logic [OP_W-1:0] OP_LAST_CODE = '1;
   localparam logic [63:0] HALF_TURN_Q60    = 64'h3243_F6A8_885A_308D;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [SLOT_W-1:0]  slot;
      logic [PITCH_W-1:0] pitch;
      logic               live;
      logic               first;
      int unsigned        idle;
      bit                 drain;
   } command_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   dprp_req_if req_bus ();
   dprp_rsp_if rsp_bus ();

   dds_pitch_record_playback_unit uut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // predictor state
   int                 sine_lut [SINE_ENTRIES];
   logic [PHASE_W-1:0] tone_step;
   logic [HOLD_W-1:0]  hold_limit;
   logic [PHASE_W-1:0] tone_phase;
   logic [PITCH_W-1:0] pitch_mem [NUM_SLOTS][SLOT_DEPTH];
   int unsigned        slot_fill [NUM_SLOTS];
   logic [SLOT_W-1:0]  seq_slots [COMPOSE_DEPTH];
   int unsigned        seq_len;
   int unsigned        seq_idx;
   int unsigned        seq_sample;
   bit                 seq_on;
   bit                 solo_on;
   logic [SLOT_W-1:0]  solo_slot;
   int unsigned        solo_pos;
   logic [HOLD_W-1:0]  hold_run;

   command_type   pending_cmds [$];
   rsp_entry_type dac_expected [$];
   command_type   cur_cmd;

   int unsigned idle_left     = 0;
   int unsigned rsp_wait      = 0;
   int unsigned cycle_count   = 0;
   int unsigned cmds_sent     = 0;
   int unsigned words_checked = 0;
   int unsigned fail_count    = 0;
   int unsigned settings_used = 0;

   // clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // truncated q60 product
   function automatic logic [63:0] q60_mul(input logic [63:0] a, input logic [63:0] b);
      logic [127:0] prod;
      prod = 128'(a) * 128'(b);
      return 64'(prod >> 60);
   endfunction

   // signed sine table entry, fixed point taylor series folded into a quarter turn
   function automatic int sine_point(input int k);
      logic [127:0] scaled;
      logic [63:0]  ang;
      logic [63:0]  x2;
      logic [63:0]  term;
      logic [63:0]  acc;
      logic [63:0]  mag;
      bit           neg;
      scaled = (128'(k) * 128'd6283) << 60;
      ang    = 64'(scaled / 128'(1000 * SINE_ENTRIES));
      neg    = 1'b0;
      if (ang > HALF_TURN_Q60) begin
         ang = ang - HALF_TURN_Q60;
         neg = 1'b1;
      end
      if (ang > (HALF_TURN_Q60 >> 1)) ang = HALF_TURN_Q60 - ang;
      x2   = q60_mul(ang, ang);
      term = ang;
      acc  = ang;
      for (int n = 1; n <= 13; n++) begin
         term = q60_mul(term, x2) / 64'(2 * n * (2 * n + 1));
         if (n % 2 == 1) acc = acc - term;
         else acc = acc + term;
      end
      // scale by 2047 and truncate
      mag = 64'((128'(acc) * 128'd2047) >> 60);
      return neg ? -int'(mag) : int'(mag);
   endfunction

   // mostly a valid slot, sometimes 0 or above the slot count
   function automatic logic [SLOT_W-1:0] random_slot();
      if ($urandom_range(0, 7) == 0) return SLOT_W'($urandom_range(NUM_SLOTS + 1, 1 << SLOT_W));
      return SLOT_W'($urandom_range(1, NUM_SLOTS));
   endfunction

   // one phase accumulator step and the dac word it gives
   task automatic advance_tone(input logic [PITCH_W-1:0] pitch);
      rsp_entry_type word;
      tone_phase    = tone_phase + tone_step * PHASE_W'(pitch);
      word.dac_word = DAC_CHAN_B | DAC_W'(sine_lut[tone_phase[PHASE_W-1 -: SINE_IDX_W]] + 2048);
      word.last     = 1'b0;
      dac_expected.push_back(word);
   endtask

   // update the predicted state for one accepted command
   task automatic apply_command(input command_type c);
      int unsigned base;
      int unsigned si;
      bit          slot_ok;
      slot_ok = (c.slot >= 1) && (c.slot <= NUM_SLOTS);
      si      = c.slot - 1;
      base    = dac_expected.size();
      case (c.op)
         OP_TICK: begin
            if (c.live) advance_tone(c.pitch);
            // composed list path
            if (seq_on) begin
               if (seq_idx < seq_len) begin
                  si = seq_slots[seq_idx] - 1;
                  if (seq_sample < slot_fill[si]) begin
                     if (hold_run < hold_limit) begin
                        advance_tone(pitch_mem[si][seq_sample]);
                        hold_run = hold_run + 1'b1;
                     end else begin
                        hold_run   = '0;
                        seq_sample = seq_sample + 1;
                     end
                  end else begin
                     seq_sample = 0;
                     seq_idx    = seq_idx + 1;
                  end
               end else begin
                  seq_idx = 0;
                  seq_len = 0;
                  seq_on  = 1'b0;
               end
            end
            // single slot path, shares the hold counter
            if (solo_on) begin
               si = solo_slot - 1;
               if (solo_pos < slot_fill[si]) begin
                  if (hold_run < hold_limit) begin
                     advance_tone(pitch_mem[si][solo_pos]);
                     hold_run = hold_run + 1'b1;
                  end else begin
                     hold_run = '0;
                     solo_pos = solo_pos + 1;
                  end
               end else begin
                  solo_pos = 0;
                  solo_on  = 1'b0;
               end
            end
            if (dac_expected.size() > base) dac_expected[dac_expected.size() - 1].last = 1'b1;
         end
         OP_RECORD: begin
            if (slot_ok) begin
               if (c.first) slot_fill[si] = 0;
               // a full slot drops the sample
               if (slot_fill[si] < SLOT_DEPTH) begin
                  pitch_mem[si][slot_fill[si]] = c.pitch;
                  slot_fill[si] = slot_fill[si] + 1;
               end
            end
         end
         OP_PLAY: begin
            if (slot_ok) begin
               solo_on   = 1'b1;
               solo_slot = c.slot;
            end
         end
         OP_APPEND: begin
            if (slot_ok && seq_len < COMPOSE_DEPTH) begin
               seq_slots[seq_len] = c.slot;
               seq_len = seq_len + 1;
            end
         end
         OP_COMPOSE: seq_on = 1'b1;
         default: ;
      endcase
   endtask

   // command driver
   always @(posedge clock) begin : cmd_driver
      bit presenting;
      presenting = req_bus.valid;
      if (reset) begin
         presenting = 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            apply_command(cur_cmd);
            cmds_sent++;
            presenting = 1'b0;
         end
         if (!presenting && pending_cmds.size() > 0) begin
            if (idle_left < pending_cmds[0].idle) begin
               idle_left++;
            end else if (!(pending_cmds[0].drain && dac_expected.size() != 0)) begin
               cur_cmd              = pending_cmds.pop_front();
               idle_left            = 0;
               presenting           = 1'b1;
               req_bus.op           <= cur_cmd.op;
               req_bus.slot         <= cur_cmd.slot;
               req_bus.pitch_value  <= cur_cmd.pitch;
               req_bus.live_on      <= cur_cmd.live;
               req_bus.first_sample <= cur_cmd.first;
            end
         end
      end
      req_bus.valid <= presenting;
   end

   // response monitor with random stalls, calm every third stretch
   always @(posedge clock) begin : rsp_monitor
      rsp_entry_type want;
      if (reset) begin
         rsp_wait = 0;
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            words_checked++;
            if (dac_expected.size() == 0) begin
               $error("dac transaction %h with no word expected", rsp_bus.dac_word);
               fail_count++;
            end else begin
               want = dac_expected.pop_front();
               if (rsp_bus.dac_word !== want.dac_word) begin
                  $error("dac_word mismatch: expected %h, actual %h",
                         want.dac_word, rsp_bus.dac_word);
                  fail_count++;
               end
               if (rsp_bus.last !== want.last) begin
                  $error("last mismatch: expected %b, actual %b", want.last, rsp_bus.last);
                  fail_count++;
               end
            end
            rsp_wait = (((words_checked / 16) % 3) == 2) ? 0 : $urandom_range(0, 3);
         end
         if (rsp_wait > 0) begin
            rsp_wait--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("run limit of %0d cycles reached", CYCLE_LIMIT);
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_cmd(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                           input logic [PITCH_W-1:0] pitch, input logic live,
                           input logic first);
      command_type c;
      c.op    = op;
      c.slot  = slot;
      c.pitch = pitch;
      c.live  = live;
      c.first = first;
      c.idle  = $urandom_range(0, 3);
      c.drain = 1'b0;
      pending_cmds.push_back(c);
   endtask

   // wait for every command and word, then let the engine go quiet
   task automatic wait_idle();
      while (pending_cmds.size() != 0 || req_bus.valid || dac_expected.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_tuning(input logic [PHASE_W-1:0] step, input logic [HOLD_W-1:0] hold);
      write_reg(CSR_PHASE_STEP, step);
      write_reg(CSR_HOLD_TICKS, CSR_DATA_W'(hold));
      tone_step  = step;
      hold_limit = hold;
      settings_used++;
   endtask

   initial begin : main_sequence
      command_type c;
      int unsigned pick;
      bit          calm;

      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = '0;
      csr_wdata            = '0;
      req_bus.valid        = 1'b0;
      req_bus.op           = OP_TICK;
      req_bus.slot         = '0;
      req_bus.pitch_value  = '0;
      req_bus.live_on      = 1'b0;
      req_bus.first_sample = 1'b0;
      rsp_bus.ready        = 1'b0;

      for (int k = 0; k < SINE_ENTRIES; k++) sine_lut[k] = sine_point(k);
      tone_step  = PHASE_STEP_RST;
      hold_limit = HOLD_TICKS_RST;
      tone_phase = '0;
      for (int i = 0; i < NUM_SLOTS; i++) slot_fill[i] = 0;
      seq_len    = 0;
      seq_idx    = 0;
      seq_sample = 0;
      seq_on     = 1'b0;
      solo_on    = 1'b0;
      solo_slot  = '0;
      solo_pos   = 0;
      hold_run   = '0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, bad slots, both paths, restarts, unused codes
      push_cmd(OP_RECORD, 4'd2, 12'hFFF, 1'b0, 1'b1);
      push_cmd(OP_RECORD, 4'd2, 12'h000, 1'b1, 1'b0);
      push_cmd(OP_RECORD, 4'd2, 12'h800, 1'b0, 1'b0);
      push_cmd(OP_RECORD, 4'd0, 12'h5A5, 1'b0, 1'b1);
      push_cmd(OP_RECORD, 4'd15, 12'hA5A, 1'b1, 1'b1);
      push_cmd(OP_TICK, 4'd15, 12'hFFF, 1'b1, 1'b1);
      push_cmd(OP_TICK, 4'd0, 12'h000, 1'b1, 1'b0);
      push_cmd(OP_TICK, 4'd7, 12'h123, 1'b0, 1'b0);
      push_cmd(OP_PLAY, 4'd0, PITCH_W'($urandom), 1'b0, 1'b0);
      push_cmd(OP_PLAY, 4'd2, PITCH_W'($urandom), 1'b1, 1'b1);
      push_cmd(OP_TICK, 4'd3, 12'h001, 1'b1, 1'b0);
      push_cmd(OP_APPEND, 4'd2, PITCH_W'($urandom), 1'b0, 1'b0);
      push_cmd(OP_APPEND, 4'd10, PITCH_W'($urandom), 1'b1, 1'b0);
      push_cmd(OP_APPEND, 4'd9, PITCH_W'($urandom), 1'b0, 1'b1);
      push_cmd(OP_APPEND, 4'd2, PITCH_W'($urandom), 1'b0, 1'b0);
      push_cmd(OP_COMPOSE, SLOT_W'($urandom), PITCH_W'($urandom), 1'b0, 1'b0);
      push_cmd(OP_TICK, 4'd8, 12'hFFF, 1'b1, 1'b0);
      push_cmd(OP_TICK, 4'd1, 12'h000, 1'b0, 1'b1);
      push_cmd(OP_PLAY, 4'd2, PITCH_W'($urandom), 1'b0, 1'b0);
      push_cmd(OP_COMPOSE + 3'd1, SLOT_W'($urandom), PITCH_W'($urandom), 1'b1, 1'b1);
      push_cmd(OP_COMPOSE + 3'd2, SLOT_W'($urandom), PITCH_W'($urandom), 1'b0, 1'b1);
      push_cmd(OP_LAST_CODE, SLOT_W'($urandom), PITCH_W'($urandom), 1'b1, 1'b0);
      push_cmd(OP_COMPOSE, SLOT_W'($urandom), PITCH_W'($urandom), 1'b1, 1'b1);
      push_cmd(OP_TICK, SLOT_W'($urandom), PITCH_W'($urandom), 1'b1, 1'b0);
      push_cmd(OP_RECORD, 4'd9, PITCH_W'($urandom), 1'b0, 1'b0);
      wait_idle();

      // fill slot 1 back to back
      set_tuning(32'h8000_0001, 8'd1);
      c.op    = OP_RECORD;
      c.slot  = 4'd1;
      c.idle  = 0;
      c.drain = 1'b0;
      for (int i = 0; i < FILL_RECORDS; i++) begin
         c.pitch = PITCH_W'($urandom);
         c.live  = 1'($urandom);
         c.first = (i == 0);
         pending_cmds.push_back(c);
      end
      // shorten slot 1 again so the list can move on
      for (int i = 0; i < 4; i++) push_cmd(OP_RECORD, 4'd1, PITCH_W'($urandom), 1'b0, i == 0);
      // overfill the compose list
      for (int i = 0; i < COMPOSE_DEPTH + 2; i++)
         push_cmd(OP_APPEND, random_slot(), PITCH_W'($urandom), 1'($urandom), 1'($urandom));
      push_cmd(OP_COMPOSE, SLOT_W'($urandom), PITCH_W'($urandom), 1'b0, 1'b0);
      push_cmd(OP_PLAY, 4'd2, PITCH_W'($urandom), 1'b0, 1'b0);
      for (int i = 0; i < 40; i++)
         push_cmd(OP_TICK, random_slot(), PITCH_W'($urandom), $urandom_range(0, 3) != 0,
                  1'($urandom));
      wait_idle();

      // random phases under different register settings
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         case (ph)
            0:       set_tuning(PHASE_W'($urandom), 8'd1);
            1:       set_tuning('0, 8'd255);
            2:       set_tuning('1, 8'd0);
            3:       set_tuning(PHASE_W'($urandom), HOLD_W'($urandom_range(2, 6)));
            default: set_tuning(PHASE_STEP_RST, HOLD_TICKS_RST);
         endcase
         for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
            calm    = ((i / 12) % 3) == 1;
            pick    = $urandom_range(0, 99);
            c.slot  = random_slot();
            c.pitch = PITCH_W'($urandom);
            c.live  = $urandom_range(0, 3) != 0;
            c.first = $urandom_range(0, 6) == 0;
            c.idle  = calm ? 0 : $urandom_range(0, 3);
            // once, hold off until every word in flight has come back
            c.drain = (ph == 0) && (i == 9);
            if (pick < 50) c.op = OP_TICK;
            else if (pick < 70) c.op = OP_RECORD;
            else if (pick < 78) c.op = OP_PLAY;
            else if (pick < 88) c.op = OP_APPEND;
            else if (pick < 95) c.op = OP_COMPOSE;
            else c.op = OP_W'($urandom_range(OP_COMPOSE + 1, OP_LAST_CODE));
            pending_cmds.push_back(c);
         end
         wait_idle();
      end

      $display("run covered %0d commands under %0d register settings", cmds_sent, settings_used);
      $display("%0d dac words compared, %0d mismatches", words_checked, fail_count);
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end

endmodule
